@@ rtl/clfl_pkg.sv @@
// Shared types and constants for the cursor list with free list.
// Used by clfl_step, cursor_list_free_list and the testbench; depends on nothing.
`timescale 1ns / 1ps

package clfl_pkg;

   // default sizes handed to the top-level parameters
   localparam int SLOTS_DEF        = 64;
   localparam int PAYLOAD_BITS_DEF = 32;

   // request opcodes
   localparam logic [2:0] OP_INIT     = 3'd0;
   localparam logic [2:0] OP_INS_HEAD = 3'd1;
   localparam logic [2:0] OP_INS_TAIL = 3'd2;
   localparam logic [2:0] OP_FREE     = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD_IDX = 2'd2;

   // the 7-bit encoding of "no slot"
   localparam logic [6:0] SLOT_NONE7 = 7'h7F;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,   // link sweep after reset, no request taken
      S_IDLE,    // ready for a request
      S_SWEEP,   // link sweep for an init request
      S_POP,     // take the free-list head, pick front or tail path
      S_WALK,    // follow links to the tail, one hop per cycle
      S_FIX,     // terminate the new tail node
      S_READ,    // capture node payload and link
      S_RESP     // hand the response to the output register
   } state_type;

   // control of the shared step counter
   typedef struct packed {
      logic clear;
      logic advance;
   } step_ctl_type;

endpackage

@@ rtl/clfl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module clfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read the addressed word into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/clfl_step.sv @@
// Shared step counter with incrementer and end-of-store compare.
// Serves both the link sweep and the tail-walk hop limit; uses clfl_pkg.
`timescale 1ns / 1ps

module clfl_step #(
   parameter int SLOTS = clfl_pkg::SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  clfl_pkg::step_ctl_type   ctl,
   output logic [$clog2(SLOTS)-1:0] count,
   output logic [$clog2(SLOTS)-1:0] count_plus,
   output logic                     at_last
);

   localparam int CW = $clog2(SLOTS);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // clear, advance or hold
   always_comb begin
      count_plus = count_ff + 1'b1;
      at_last    = (count_ff == CW'(SLOTS - 1));
      priority if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.advance) begin
         count_in = count_plus;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

@@ rtl/cursor_list_free_list.sv @@
// Cursor-based linked list with a free list, over a fixed node store.
// Depends on clfl_pkg, clfl_ram (payload and link stores) and clfl_step.
// Usage:
//   req_* stream carries one request (init, insert at front, insert at tail,
//   free a slot, read a node); rsp_* stream returns exactly one response per
//   request. Requests are taken one at a time: req_tready is high only while
//   the sequencer is idle.
//   States a request passes from accept to rsp_tvalid, with the receiver ready:
//     free, invalid index, unknown opcode, store full: response
//     insert at front: pop, response; read: read, response
//     insert at tail: pop, walk (hops <= SLOTS-1), fix, response
//     init:           sweep, response; walk and sweep go one link per cycle
//   req_tready rises again together with rsp_tvalid. The walk and the sweep
//   share one step counter and the link store's single write port.
//   Reset: a clearing pass chains every slot into the free list; req_tready
//   stays low meanwhile. Payloads are not cleared.
//   Receiver stall: the response waits in the output register; the block
//   takes the next request but holds its response until the register frees.
`timescale 1ns / 1ps

module cursor_list_free_list #(
   parameter int SLOTS        = clfl_pkg::SLOTS_DEF,
   parameter int PAYLOAD_BITS = clfl_pkg::PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: opcode[2:0], payload[34:3], slot_index[41:35], zero[47:42]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: status[1:0], slot[8:2], node_payload[40:9], next_link[47:41],
   //           head_now[54:48], zero[55]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata
);

   localparam int SW = $clog2(SLOTS);      // slot index bits
   localparam int LW = SW + 1;             // link: {none, index}
   localparam int IW = SW + 7;             // room for index and 7-bit fields
   localparam int PW = PAYLOAD_BITS + 32;  // room for payload resizing
   localparam logic [LW-1:0] LINK_NONE = {1'b1, {SW{1'b0}}};

   // request fields
   logic [2:0]              req_op;
   logic [31:0]             req_pay;
   logic [6:0]              req_idx;
   logic [IW-1:0]           idx_wide;
   logic                    idx_ok;
   logic [SW-1:0]           idx;
   logic [PW-1:0]           pay_wide;
   logic [PAYLOAD_BITS-1:0] pay_store;

   // state
   clfl_pkg::state_type state_ff, state_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] list_head_ff, list_head_in;
   logic [SW-1:0] new_ff, new_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic          at_tail_ff, at_tail_in;

   // pending result
   logic [1:0]  res_status_ff, res_status_in;
   logic [6:0]  res_slot_ff, res_slot_in;
   logic [31:0] res_pay_ff, res_pay_in;
   logic [6:0]  res_next_ff, res_next_in;

   // output register
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_pay_ff, rsp_pay_in;
   logic [6:0]  rsp_next_ff, rsp_next_in;
   logic [6:0]  rsp_head_ff, rsp_head_in;
   logic        out_free;

   // store ports
   logic                    link_we;
   logic [SW-1:0]           link_waddr;
   logic [LW-1:0]           link_wdata;
   logic [SW-1:0]           link_raddr;
   logic [LW-1:0]           link_rdata;
   logic                    pay_we;
   logic [PAYLOAD_BITS-1:0] pay_rdata;
   logic [PW-1:0]           pay_rd_wide;

   // step counter
   clfl_pkg::step_ctl_type step_ctl;
   logic [SW-1:0]          step_count;
   logic [SW-1:0]          step_plus;
   logic                   step_last;

   // map a link to the 7-bit slot field
   function automatic logic [6:0] to_slot7(input logic [LW-1:0] link);
      logic [IW-1:0] w;
      w = IW'(link[SW-1:0]);
      return link[LW-1] ? clfl_pkg::SLOT_NONE7 : w[6:0];
   endfunction

   // unpack and check the request
   assign req_op    = req_tdata[2:0];
   assign req_pay   = req_tdata[34:3];
   assign req_idx   = req_tdata[41:35];
   assign idx_wide  = IW'(req_idx[5:0]);
   assign idx_ok    = !req_idx[6] && (idx_wide < IW'(SLOTS));
   assign idx       = idx_wide[SW-1:0];
   assign pay_wide  = PW'(req_pay);
   assign pay_store = pay_wide[PAYLOAD_BITS-1:0];
   assign pay_rd_wide = PW'(pay_rdata);

   assign req_tready = (state_ff == clfl_pkg::S_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // stores and the shared step counter
   clfl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   clfl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (new_in),
      .wr_data (pay_store),
      .rd_addr (idx),
      .rd_data (pay_rdata)
   );

   clfl_step #(.SLOTS(SLOTS)) u_step (
      .clock      (clock),
      .reset      (reset),
      .ctl        (step_ctl),
      .count      (step_count),
      .count_plus (step_plus),
      .at_last    (step_last)
   );

   // sequencer: next state, store accesses, result
   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      list_head_in  = list_head_ff;
      new_in        = new_ff;
      tail_in       = tail_ff;
      at_tail_in    = at_tail_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pay_in    = res_pay_ff;
      res_next_in   = res_next_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_head_in   = rsp_head_ff;
      link_we       = 1'b0;
      link_waddr    = '0;
      link_wdata    = LINK_NONE;
      link_raddr    = '0;
      pay_we        = 1'b0;
      step_ctl      = '{clear: 1'b0, advance: 1'b0};

      unique case (state_ff)
         clfl_pkg::S_CLEAR, clfl_pkg::S_SWEEP: begin
            // chain slot i to i+1, last slot to none
            link_we          = 1'b1;
            link_waddr       = step_count;
            link_wdata       = step_last ? LINK_NONE : {1'b0, step_plus};
            step_ctl.advance = 1'b1;
            if (step_last) begin
               free_head_in = '0;
               list_head_in = LINK_NONE;
               state_in     = (state_ff == clfl_pkg::S_CLEAR) ?
                              clfl_pkg::S_IDLE : clfl_pkg::S_RESP;
            end
         end

         clfl_pkg::S_IDLE: begin
            if (req_tvalid) begin
               res_status_in = clfl_pkg::ST_OK;
               res_slot_in   = clfl_pkg::SLOT_NONE7;
               res_pay_in    = '0;
               res_next_in   = clfl_pkg::SLOT_NONE7;
               state_in      = clfl_pkg::S_RESP;
               unique case (req_op)
                  clfl_pkg::OP_INIT: begin
                     step_ctl.clear = 1'b1;
                     state_in       = clfl_pkg::S_SWEEP;
                  end
                  clfl_pkg::OP_INS_HEAD, clfl_pkg::OP_INS_TAIL: begin
                     if (free_head_ff[LW-1]) begin
                        res_status_in = clfl_pkg::ST_FULL;
                     end else begin
                        // pop the free head, store the payload there
                        new_in      = free_head_ff[SW-1:0];
                        at_tail_in  = (req_op == clfl_pkg::OP_INS_TAIL);
                        link_raddr  = free_head_ff[SW-1:0];
                        pay_we      = 1'b1;
                        res_slot_in = to_slot7(free_head_ff);
                        state_in    = clfl_pkg::S_POP;
                     end
                  end
                  clfl_pkg::OP_FREE: begin
                     if (idx_ok) begin
                        link_we      = 1'b1;
                        link_waddr   = idx;
                        link_wdata   = free_head_ff;
                        free_head_in = {1'b0, idx};
                        res_slot_in  = to_slot7({1'b0, idx});
                     end else begin
                        res_status_in = clfl_pkg::ST_BAD_IDX;
                     end
                  end
                  clfl_pkg::OP_READ: begin
                     if (idx_ok) begin
                        link_raddr  = idx;
                        res_slot_in = to_slot7({1'b0, idx});
                        state_in    = clfl_pkg::S_READ;
                     end else begin
                        res_status_in = clfl_pkg::ST_BAD_IDX;
                     end
                  end
                  default: begin
                     // unknown opcode: no change, plain response
                  end
               endcase
            end
         end

         clfl_pkg::S_POP: begin
            // link of the popped slot becomes the free head
            free_head_in = link_rdata;
            if (!at_tail_ff || list_head_ff[LW-1]) begin
               link_we      = 1'b1;
               link_waddr   = new_ff;
               link_wdata   = list_head_ff;
               list_head_in = {1'b0, new_ff};
               state_in     = clfl_pkg::S_RESP;
            end else begin
               link_raddr     = list_head_ff[SW-1:0];
               tail_in        = list_head_ff[SW-1:0];
               step_ctl.clear = 1'b1;
               state_in       = clfl_pkg::S_WALK;
            end
         end

         clfl_pkg::S_WALK: begin
            // follow one link per cycle until none or the hop limit
            if (!step_last && !link_rdata[LW-1]) begin
               tail_in          = link_rdata[SW-1:0];
               link_raddr       = link_rdata[SW-1:0];
               step_ctl.advance = 1'b1;
            end else begin
               link_we    = 1'b1;
               link_waddr = tail_ff;
               link_wdata = {1'b0, new_ff};
               state_in   = clfl_pkg::S_FIX;
            end
         end

         clfl_pkg::S_FIX: begin
            link_we    = 1'b1;
            link_waddr = new_ff;
            link_wdata = LINK_NONE;
            state_in   = clfl_pkg::S_RESP;
         end

         clfl_pkg::S_READ: begin
            res_pay_in  = pay_rd_wide[31:0];
            res_next_in = to_slot7(link_rdata);
            state_in    = clfl_pkg::S_RESP;
         end

         clfl_pkg::S_RESP: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_next_in   = res_next_ff;
               rsp_head_in   = to_slot7(list_head_ff);
               state_in      = clfl_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = clfl_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clfl_pkg::S_CLEAR;
         free_head_ff  <= '0;
         list_head_ff  <= LINK_NONE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         list_head_ff  <= list_head_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_ff        <= new_in;
      tail_ff       <= tail_in;
      at_tail_ff    <= at_tail_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pay_ff    <= res_pay_in;
      res_next_ff   <= res_next_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_head_ff   <= rsp_head_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_head_ff, rsp_next_ff, rsp_pay_ff, rsp_slot_ff,
                        rsp_status_ff};

   // no request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clfl_pkg::S_CLEAR) |-> !req_tready)
      else $error("request ready during clearing pass");

   // a new response comes only out of the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == clfl_pkg::S_RESP))
      else $error("response raised outside the response state");

   // links met on the walk stay inside the store
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clfl_pkg::S_WALK && !link_rdata[LW-1]) |->
      (IW'(link_rdata[SW-1:0]) < IW'(SLOTS)))
      else $error("walk reached a link outside the store");

endmodule

@@ verif/tb_cursor_list_free_list.sv @@
// Self-checking testbench for cursor_list_free_list: list and free-list shadow,
// directed and random requests, response checks. Depends on clfl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_cursor_list_free_list;

   localparam int SLOTS        = clfl_pkg::SLOTS_DEF;
   localparam int ITEM_TARGET  = 900;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int PRINT_CAP    = 40;

   // opcodes the block must ignore
   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   // most negative 7-bit index, reads as 64 unsigned
   localparam logic [6:0] IDX_MOST_NEG = 7'h40;

   typedef logic signed [6:0] cursor_type;

   typedef struct {
      logic [1:0]  status;
      cursor_type  slot;
      logic [31:0] data;
      cursor_type  next;
      cursor_type  head;
   } node_rsp_type;

   // Shadow of the node store; queues one expected response per request.
   class cursor_list_shadow;
      logic [31:0]  node_data [SLOTS];
      cursor_type   node_next [SLOTS];
      bit           node_written [SLOTS];
      cursor_type   free_top;
      cursor_type   list_top;
      node_rsp_type awaited [$];
      node_rsp_type last_rsp;
      int           mismatches;
      int           responses_seen;
      int           walk_max;
      int           op_seen [8];
      int           status_seen [4];

      function new();
         foreach (node_data[i]) begin
            node_data[i]    = '0;
            node_written[i] = 1'b0;
         end
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches     = 0;
         responses_seen = 0;
         walk_max       = 0;
         chain_all();
      endfunction

      function bit in_range(cursor_type c);
         return (c >= 0) && (int'(c) < SLOTS);
      endfunction

      function cursor_type clean(cursor_type c);
         return in_range(c) ? c : cursor_type'(clfl_pkg::SLOT_NONE7);
      endfunction

      // chain every slot into the free list and empty the list
      function void chain_all();
         for (int i = 0; i < SLOTS - 1; i++) node_next[i] = cursor_type'(i + 1);
         node_next[SLOTS-1] = clfl_pkg::SLOT_NONE7;
         free_top = '0;
         list_top = clfl_pkg::SLOT_NONE7;
      endfunction

      // any slot whose payload has been written, or none
      function cursor_type pick_readable();
         cursor_type picks [$];
         foreach (node_written[i]) if (node_written[i]) picks.push_back(cursor_type'(i));
         if (picks.size() == 0) return clfl_pkg::SLOT_NONE7;
         return picks[$urandom_range(picks.size() - 1)];
      endfunction

      // advance the shadow by one accepted request and queue its response
      function void apply_request(logic [2:0] op, logic [31:0] pay, cursor_type idx);
         node_rsp_type r;
         cursor_type   n;
         cursor_type   t;
         int           hops;
         r.status = clfl_pkg::ST_OK;
         r.slot   = clfl_pkg::SLOT_NONE7;
         r.data   = '0;
         r.next   = clfl_pkg::SLOT_NONE7;
         op_seen[op]++;
         case (op)
            clfl_pkg::OP_INIT: begin
               chain_all();
            end
            clfl_pkg::OP_INS_HEAD, clfl_pkg::OP_INS_TAIL: begin
               n = clean(free_top);
               if (!in_range(n)) begin
                  r.status = clfl_pkg::ST_FULL;
               end else begin
                  free_top        = clean(node_next[n]);
                  r.slot          = n;
                  node_data[n]    = pay;
                  node_written[n] = 1'b1;
                  if (op == clfl_pkg::OP_INS_HEAD || !in_range(list_top)) begin
                     node_next[n] = clean(list_top);
                     list_top     = n;
                  end else begin
                     // walk to the last node; the new node's link is still stale here
                     t    = list_top;
                     hops = 0;
                     while (hops < SLOTS - 1 && in_range(node_next[t])) begin
                        t = node_next[t];
                        hops++;
                     end
                     if (hops > walk_max) walk_max = hops;
                     node_next[t] = n;
                     node_next[n] = clfl_pkg::SLOT_NONE7;
                  end
               end
            end
            clfl_pkg::OP_FREE: begin
               if (!in_range(idx)) begin
                  r.status = clfl_pkg::ST_BAD_IDX;
               end else begin
                  node_next[idx] = clean(free_top);
                  free_top       = idx;
                  r.slot         = idx;
               end
            end
            clfl_pkg::OP_READ: begin
               if (!in_range(idx)) begin
                  r.status = clfl_pkg::ST_BAD_IDX;
               end else begin
                  r.slot = idx;
                  r.data = node_data[idx];
                  r.next = clean(node_next[idx]);
               end
            end
            default: ;
         endcase
         r.head = clean(list_top);
         status_seen[r.status]++;
         last_rsp = r;
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t ns: response %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, responses_seen, what, got, want);
      endtask

      // compare one accepted response with the oldest expectation
      task match_response(logic [55:0] d);
         node_rsp_type want;
         responses_seen++;
         if (awaited.size() == 0) begin
            report_mismatch("response with no request outstanding", d[31:0], '0);
            return;
         end
         want = awaited.pop_front();
         if (d[1:0] !== want.status)
            report_mismatch("status", 32'(d[1:0]), 32'(want.status));
         if (d[8:2] !== want.slot)
            report_mismatch("slot", 32'(d[8:2]), 32'(7'(want.slot)));
         if (d[40:9] !== want.data)
            report_mismatch("node_payload", d[40:9], want.data);
         if (d[47:41] !== want.next)
            report_mismatch("next_link", 32'(d[47:41]), 32'(7'(want.next)));
         if (d[54:48] !== want.head)
            report_mismatch("head_now", 32'(d[54:48]), 32'(7'(want.head)));
         if (d[55] !== 1'b0)
            report_mismatch("pad bit", 32'(d[55]), '0);
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   cursor_list_shadow shadow = new();
   int          send_idle_pct = 28;
   int          recv_idle_pct = 69;
   int          items_accepted = 0;
   cursor_type  live_slots [$];
   cursor_type  freed_slots [$];

   cursor_list_free_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // check every response handed over
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.match_response(rsp_tdata);
   end

   // receiver: random stalls, plus one long hold so the block backs up
   initial begin : rsp_side
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_used && items_accepted >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // offer one request, wait for its handshake, track allocated and freed slots
   task automatic issue_request(input logic [2:0] op, input logic [31:0] pay,
                                input logic [6:0] idx);
      int pos;
      if (op == clfl_pkg::OP_READ && shadow.in_range(idx) && !shadow.node_written[idx])
         idx = shadow.pick_readable();
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, idx, pay, op};
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(op, pay, idx);
      items_accepted++;
      if (shadow.last_rsp.status == clfl_pkg::ST_OK) begin
         case (op)
            clfl_pkg::OP_INIT: live_slots.delete();
            clfl_pkg::OP_INS_HEAD, clfl_pkg::OP_INS_TAIL:
               live_slots.push_back(shadow.last_rsp.slot);
            clfl_pkg::OP_FREE: begin
               pos = -1;
               foreach (live_slots[i]) if (live_slots[i] == idx) pos = i;
               if (pos >= 0) live_slots.delete(pos);
               freed_slots.push_back(idx);
               if (freed_slots.size() > 8) void'(freed_slots.pop_front());
            end
            default: ;
         endcase
      end
   endtask

   // hold the sender until every outstanding response has come back
   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase;
      int r;
      int fill_len;
      logic [2:0] op;
      cursor_type pick;
      phase = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: bad indexes, front and tail inserts, stale free that makes a
      // cycle, tail walk cut off by the hop limit, double free, ignored opcodes, init
      issue_request(clfl_pkg::OP_READ, 32'h0, clfl_pkg::SLOT_NONE7);
      issue_request(clfl_pkg::OP_READ, 32'h0, IDX_MOST_NEG);
      issue_request(clfl_pkg::OP_FREE, 32'h0, clfl_pkg::SLOT_NONE7);
      issue_request(clfl_pkg::OP_FREE, 32'hFFFF_FFFF, IDX_MOST_NEG);
      issue_request(clfl_pkg::OP_INS_HEAD, 32'h0000_0000, '0);
      issue_request(clfl_pkg::OP_INS_TAIL, 32'hFFFF_FFFF, clfl_pkg::SLOT_NONE7);
      issue_request(clfl_pkg::OP_INS_TAIL, 32'hA5A5_A5A5, '0);
      issue_request(clfl_pkg::OP_READ, 32'h0, 7'd0);
      issue_request(clfl_pkg::OP_READ, 32'h0, 7'd2);
      issue_request(clfl_pkg::OP_FREE, 32'h0, 7'd1);
      issue_request(clfl_pkg::OP_INS_HEAD, 32'h5A5A_5A5A, '0);
      issue_request(clfl_pkg::OP_INS_TAIL, 32'h0000_0001, '0);
      issue_request(clfl_pkg::OP_READ, 32'h0, 7'd1);
      issue_request(clfl_pkg::OP_FREE, 32'h0, 7'(SLOTS - 1));
      issue_request(clfl_pkg::OP_FREE, 32'h0, 7'(SLOTS - 1));
      issue_request(clfl_pkg::OP_INS_HEAD, 32'h8000_0000, '0);
      issue_request(clfl_pkg::OP_INS_HEAD, 32'h7FFF_FFFF, '0);
      issue_request(clfl_pkg::OP_READ, 32'h0, 7'(SLOTS - 1));
      issue_request(OP_RSVD_5, 32'hFFFF_FFFF, clfl_pkg::SLOT_NONE7);
      issue_request(OP_RSVD_6, 32'h0, '0);
      issue_request(OP_RSVD_7, 32'h1234_5678, IDX_MOST_NEG);
      issue_request(clfl_pkg::OP_INIT, 32'hFFFF_FFFF, clfl_pkg::SLOT_NONE7);
      issue_request(clfl_pkg::OP_READ, 32'h0, 7'(SLOTS - 1));
      issue_request(clfl_pkg::OP_INS_TAIL, 32'hC3C3_C3C3, '0);

      // random segments: fill to full, churn, and raw noise
      while (items_accepted < ITEM_TARGET) begin
         if (phase == 0 && items_accepted >= ITEM_TARGET / 3) begin
            wait_all_answered();
            send_idle_pct = 69;
            recv_idle_pct = 28;
            phase = 1;
         end else if (phase == 1 && items_accepted >= 2 * ITEM_TARGET / 3) begin
            wait_all_answered();
            send_idle_pct = 0;
            recv_idle_pct = 0;
            phase = 2;
         end
         r = $urandom_range(3);
         if (r == 0) begin
            // init, then insert past full with reads of live nodes mixed in
            issue_request(clfl_pkg::OP_INIT, $urandom, 7'($urandom_range(127)));
            fill_len = SLOTS + 1 + $urandom_range(3);
            repeat (fill_len) begin
               op = $urandom_range(1) ? clfl_pkg::OP_INS_TAIL : clfl_pkg::OP_INS_HEAD;
               issue_request(op, $urandom, 7'($urandom_range(127)));
               if (live_slots.size() != 0 && $urandom_range(4) == 0)
                  issue_request(clfl_pkg::OP_READ, $urandom,
                                live_slots[$urandom_range(live_slots.size() - 1)]);
            end
         end else if (r == 3) begin
            // noise: every field at random
            repeat (20)
               issue_request(3'($urandom_range(7)), $urandom, 7'($urandom_range(127)));
         end else begin
            // churn: mostly well-formed allocate, free and read traffic
            repeat (40) begin
               r = $urandom_range(99);
               if (r < 22) begin
                  issue_request(clfl_pkg::OP_INS_HEAD, $urandom, 7'($urandom_range(127)));
               end else if (r < 44) begin
                  issue_request(clfl_pkg::OP_INS_TAIL, $urandom, 7'($urandom_range(127)));
               end else if (r < 62 && live_slots.size() != 0) begin
                  pick = live_slots[$urandom_range(live_slots.size() - 1)];
                  issue_request(clfl_pkg::OP_FREE, $urandom, pick);
               end else if (r < 82) begin
                  issue_request(clfl_pkg::OP_READ, $urandom, shadow.pick_readable());
               end else if (r < 86 && freed_slots.size() != 0) begin
                  pick = freed_slots[$urandom_range(freed_slots.size() - 1)];
                  issue_request(clfl_pkg::OP_FREE, $urandom, pick);
               end else if (r < 91) begin
                  op = $urandom_range(1) ? clfl_pkg::OP_FREE : clfl_pkg::OP_READ;
                  issue_request(op, $urandom, 7'($urandom_range(127, 64)));
               end else if (r < 95) begin
                  issue_request(3'($urandom_range(OP_RSVD_7, OP_RSVD_5)), $urandom,
                                7'($urandom_range(127)));
               end else if (r < 97) begin
                  issue_request(clfl_pkg::OP_INIT, $urandom, 7'($urandom_range(127)));
               end else begin
                  issue_request(clfl_pkg::OP_INS_HEAD,
                                $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
                                7'($urandom_range(127)));
               end
            end
         end
      end

      // drain, then allow time for any stray response
      wait_all_answered();
      repeat (SLOTS + 8) @(posedge clock);

      $display("covered %0d requests: init %0d, front %0d, tail %0d, free %0d,",
               items_accepted, shadow.op_seen[clfl_pkg::OP_INIT],
               shadow.op_seen[clfl_pkg::OP_INS_HEAD], shadow.op_seen[clfl_pkg::OP_INS_TAIL],
               shadow.op_seen[clfl_pkg::OP_FREE]);
      $display("  read %0d, ignored %0d, store full %0d, bad index %0d, longest walk %0d hops",
               shadow.op_seen[clfl_pkg::OP_READ],
               shadow.op_seen[OP_RSVD_5] + shadow.op_seen[OP_RSVD_6] +
               shadow.op_seen[OP_RSVD_7],
               shadow.status_seen[clfl_pkg::ST_FULL], shadow.status_seen[clfl_pkg::ST_BAD_IDX],
               shadow.walk_max);
      if (shadow.mismatches == 0) begin
         $display("tb_cursor_list_free_list: PASS");
      end else begin
         $display("tb_cursor_list_free_list: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #5_000_000;
      $display("timeout at %0t ns with %0d requests accepted", $time, items_accepted);
      $display("tb_cursor_list_free_list: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/clfl_pkg.sv
rtl/clfl_ram.sv
rtl/clfl_step.sv
rtl/cursor_list_free_list.sv
verif/tb_cursor_list_free_list.sv
